@@ design/phit_pkg.sv @@
// ----------------------------------------------------------------------------
// phit_pkg: shared types and constants of the polyline hit test
// Point, box and command formats, store sizes and op codes.
// ----------------------------------------------------------------------------
package phit_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int GROUP_SIZE = 8;
  localparam int LEAF_COUNT = (MAX_POINTS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int LEAF_AW    = $clog2(LEAF_COUNT);
  localparam int OFF_W      = $clog2(GROUP_SIZE);
  localparam int CNT_W      = PT_AW + 1;
  localparam int COORD_W    = 20;
  localparam int HW_W       = 16;
  localparam logic [HW_W-1:0] HW_RESET = 16'd16;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t lox;
    coord_t loy;
    coord_t hix;
    coord_t hiy;
  } box_t;

  typedef struct packed {
    op_t    op;
    point_t pt;
  } cmd_t;

endpackage

@@ design/phit_front.sv @@
// ----------------------------------------------------------------------------
// phit_front: input stage
// Registers one transaction, decodes its op and hands it to the queue.
// ----------------------------------------------------------------------------
module phit_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic signed [19:0]       in_x,
  input  logic signed [19:0]       in_y,
  output phit_pkg::cmd_t           cmd,
  output logic                     cmd_valid,
  input  logic                     q_full
);
  import phit_pkg::*;

  logic cmd_valid_r, cmd_valid_nxt;
  cmd_t cmd_r;
  op_t  op_dec;

  // Every 2-bit code is an op_t member, the unused one included.
  assign op_dec = op_t'(in_op);

  assign in_stall  = cmd_valid_r && q_full;
  assign cmd       = cmd_r;
  assign cmd_valid = cmd_valid_r;

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (!in_stall) begin
      cmd_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
    if (!in_stall && in_valid) begin
      cmd_r <= '{op: op_dec, pt: '{x: in_x, y: in_y}};
    end
  end

endmodule

@@ design/phit_queue.sv @@
// ----------------------------------------------------------------------------
// phit_queue: two-entry command queue
// Decouples the input stage from the executing back end.
// ----------------------------------------------------------------------------
module phit_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  phit_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output phit_pkg::cmd_t head
);
  import phit_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

@@ design/phit_back.sv @@
// ----------------------------------------------------------------------------
// phit_back: command execution
// Holds the point and leaf box stores and runs clear, append and query.
// ----------------------------------------------------------------------------
module phit_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                cmd_avail,
  input  phit_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic                out_error
);
  import phit_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_BOX_RD  = 7'b0000010,
    S_BOX_CHK = 7'b0000100,
    S_PT_RD   = 7'b0001000,
    S_PT_MUL  = 7'b0010000,
    S_PT_CMP  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  point_t pt_mem [MAX_POINTS];
  box_t   box_mem [LEAF_COUNT];
  point_t pt_q;
  box_t   box_q;

  logic [HW_W-1:0]    hw_r;
  logic [2*HW_W-1:0]  hw2_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_m1;
  logic [LEAF_AW-1:0] g_r, g_nxt;
  logic [PT_AW-1:0]   k_r, k_nxt;
  point_t             q_r;
  box_t               cur_box_r, box_upd;
  logic               out_valid_r, out_valid_nxt, hit_r, hit_nxt, err_r, err_nxt;
  logic [40:0]        sqx_r, sqy_r;
  logic signed [20:0] dx, dy;
  logic signed [41:0] px2, py2;
  logic [41:0]        dist2;
  logic signed [21:0] hw_s, qx_s, qy_s;
  logic               in_box, pt_hit, last_g, last_k;
  logic               start, full;

  assign out_valid = out_valid_r;
  assign out_hit   = hit_r;
  assign out_error = err_r;

  assign full   = cnt_r[CNT_W-1];
  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign start  = (state_r == S_IDLE) && cmd_avail && !out_valid_r;
  assign cmd_pop = start;

  // Box padded by half width, edges inclusive.
  always_comb begin
    hw_s = signed'({6'b0, hw_r});
    qx_s = 22'(q_r.x);
    qy_s = 22'(q_r.y);
    in_box = !(qx_s < 22'(box_q.lox) - hw_s) && !(qx_s > 22'(box_q.hix) + hw_s) &&
             !(qy_s < 22'(box_q.loy) - hw_s) && !(qy_s > 22'(box_q.hiy) + hw_s);
  end

  always_comb begin
    dx    = 21'(q_r.x) - 21'(pt_q.x);
    dy    = 21'(q_r.y) - 21'(pt_q.y);
    px2   = dx * dx;
    py2   = dy * dy;
    dist2 = {1'b0, sqx_r} + {1'b0, sqy_r};
    pt_hit = dist2 < {10'b0, hw2_r};
  end

  assign last_g = g_r == cnt_m1[PT_AW-1:OFF_W];
  assign last_k = (k_r[OFF_W-1:0] == OFF_W'(GROUP_SIZE - 1)) || (k_r == cnt_m1[PT_AW-1:0]);

  // Box of the open group; this append is folded in at even offsets.
  always_comb begin
    box_upd = cur_box_r;
    if (cnt_r[OFF_W-1:0] == '0) begin
      box_upd = '{lox: cmd.pt.x, loy: cmd.pt.y, hix: cmd.pt.x, hiy: cmd.pt.y};
    end else if (!cnt_r[0]) begin
      if (cmd.pt.x < cur_box_r.lox) box_upd.lox = cmd.pt.x;
      if (cmd.pt.x > cur_box_r.hix) box_upd.hix = cmd.pt.x;
      if (cmd.pt.y < cur_box_r.loy) box_upd.loy = cmd.pt.y;
      if (cmd.pt.y > cur_box_r.hiy) box_upd.hiy = cmd.pt.y;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    g_nxt         = g_r;
    k_nxt         = k_r;
    hit_nxt       = hit_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          hit_nxt = 1'b0;
          err_nxt = 1'b0;
          case (cmd.op)
            OP_CLEAR: begin
              cnt_nxt = '0;
              out_valid_nxt = 1'b1;
            end
            OP_APPEND: begin
              if (full) err_nxt = 1'b1;
              else cnt_nxt = cnt_r + CNT_W'(1);
              out_valid_nxt = 1'b1;
            end
            OP_QUERY: begin
              if (cnt_r == '0) begin
                err_nxt = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                g_nxt = '0;
                state_nxt = S_BOX_RD;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_BOX_RD: state_nxt = S_BOX_CHK;
      S_BOX_CHK: begin
        if (in_box) begin
          k_nxt = {g_r, OFF_W'(0)};
          state_nxt = S_PT_RD;
        end else if (last_g) begin
          state_nxt = S_DONE;
        end else begin
          g_nxt = g_r + LEAF_AW'(1);
          state_nxt = S_BOX_RD;
        end
      end
      S_PT_RD:  state_nxt = S_PT_MUL;
      S_PT_MUL: state_nxt = S_PT_CMP;
      S_PT_CMP: begin
        if (pt_hit) begin
          hit_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (!last_k) begin
          k_nxt = k_r + PT_AW'(1);
          state_nxt = S_PT_RD;
        end else if (last_g) begin
          state_nxt = S_DONE;
        end else begin
          g_nxt = g_r + LEAF_AW'(1);
          state_nxt = S_BOX_RD;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      hw_r        <= HW_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) hw_r <= cfg_wdata;
    end
    g_r   <= g_nxt;
    k_r   <= k_nxt;
    hit_r <= hit_nxt;
    err_r <= err_nxt;
    sqx_r <= px2[40:0];
    sqy_r <= py2[40:0];
    if (start) begin
      q_r   <= cmd.pt;
      hw2_r <= hw_r * hw_r;
    end
    if (start && cmd.op == OP_APPEND && !full) begin
      pt_mem[cnt_r[PT_AW-1:0]]        <= cmd.pt;
      box_mem[cnt_r[PT_AW-1:OFF_W]]   <= box_upd;
      cur_box_r                       <= box_upd;
    end
    pt_q  <= pt_mem[k_r];
    box_q <= box_mem[g_r];
  end

endmodule

@@ design/polyline_hit_test.sv @@
// ----------------------------------------------------------------------------
// polyline_hit_test: point hit test against a stroked polyline
// Stores up to 1024 center points in leaves of eight and answers queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, in_op, in_x, in_y) carries one
//   transaction per op: clear, append point or query point. Output channel
//   (out_valid / out_stall, out_hit, out_error) returns exactly one result
//   transaction per input transaction, in order.
//   cfg_we / cfg_wdata write the half stroke width; write only while idle.
// Sequencing:
//   Clear, append and unused op: input register, then queue and execute; a
//   command starts only once the previous result is taken.
//   Query: input register and queue, then a box read and test per leaf,
//   plus one point store read, a multiply stage and a compare stage per
//   point of each leaf whose padded box holds the query point, then a
//   finishing state; the first hit ends the search. The single read port of
//   each store and the sequencer set this sequence.
// Reset: point count goes to zero, half width to 16, queue and output empty.
// Stall: a waiting result holds in the output register; the back end idles,
//   the two-entry queue and input register keep taking transactions until
//   they fill, then in_stall rises.
module polyline_hit_test (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic signed [19:0] in_x,
  input  logic signed [19:0] in_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic               out_error,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import phit_pkg::*;

  cmd_t front_cmd, q_head;
  logic front_valid, q_full, q_not_empty, q_pop;

  // Accept and decode transactions.
  phit_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_x      (in_x),
    .in_y      (in_y),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .q_full    (q_full)
  );

  // Buffer decoded commands so front and back stall on their own.
  phit_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Execute commands against the stores.
  phit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_avail (q_not_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_hit   (out_hit),
    .out_error (out_error)
  );

endmodule

@@ verif/polyline_hit_test_chk.sv @@
// ----------------------------------------------------------------------------
// polyline_hit_test_chk: result checker of the polyline hit test
// Watches both channels, predicts hit and error per transaction, compares.
// ----------------------------------------------------------------------------
module polyline_hit_test_chk
  import phit_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic signed [19:0] in_x,
  input  logic signed [19:0] in_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic               out_error,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic hit;
    logic error;
  } verdict_t;

  coord_t        pts_x [MAX_POINTS];
  coord_t        pts_y [MAX_POINTS];
  box_t          boxes [LEAF_COUNT];
  int            n_pts;
  logic [15:0]   hw;
  verdict_t      verdicts [$];

  function automatic logic stroke_hit(coord_t qx, coord_t qy);
    longint r, r2, dx, dy;
    int     groups, last;
    r = longint'(hw);
    r2 = r * r;
    groups = (n_pts + GROUP_SIZE - 1) / GROUP_SIZE;
    for (int g = 0; g < groups; g++) begin
      if (longint'(qx) < longint'(boxes[g].lox) - r ||
          longint'(qx) > longint'(boxes[g].hix) + r ||
          longint'(qy) < longint'(boxes[g].loy) - r ||
          longint'(qy) > longint'(boxes[g].hiy) + r) continue;
      last = g * GROUP_SIZE + GROUP_SIZE - 1;
      if (last > n_pts - 1) last = n_pts - 1;
      for (int k = g * GROUP_SIZE; k <= last; k++) begin
        dx = longint'(qx) - longint'(pts_x[k]);
        dy = longint'(qy) - longint'(pts_y[k]);
        if (dx * dx + dy * dy < r2) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    verdict_t v, e;
    int       g, off;
    if (!rst_n) begin
      n_pts = 0;
      hw <= HW_RESET;
      fail_count <= 0;
      pending <= 0;
      verdicts.delete();
    end else begin
      if (cfg_we) hw <= cfg_wdata;
      if (in_valid && !in_stall) begin
        v = '0;
        case (op_t'(in_op))
          OP_CLEAR: n_pts = 0;
          OP_APPEND: begin
            if (n_pts >= MAX_POINTS) v.error = 1'b1;
            else begin
              g = n_pts / GROUP_SIZE;
              off = n_pts % GROUP_SIZE;
              pts_x[n_pts] = in_x;
              pts_y[n_pts] = in_y;
              if (off == 0) boxes[g] = '{in_x, in_y, in_x, in_y};
              else if (off % 2 == 0) begin
                if (in_x < boxes[g].lox) boxes[g].lox = in_x;
                if (in_x > boxes[g].hix) boxes[g].hix = in_x;
                if (in_y < boxes[g].loy) boxes[g].loy = in_y;
                if (in_y > boxes[g].hiy) boxes[g].hiy = in_y;
              end
              n_pts = n_pts + 1;
            end
          end
          OP_QUERY: begin
            if (n_pts == 0) v.error = 1'b1;
            else v.hit = stroke_hit(in_x, in_y);
          end
          default: ;
        endcase
        verdicts = {verdicts, v};
      end
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          $display("%0t: result with none expected: actual hit=%0b error=%0b",
                   $time, out_hit, out_error);
          fail_count <= fail_count + 1;
        end else begin
          e = verdicts.pop_front();
          if (e.hit !== out_hit || e.error !== out_error) begin
            $display("%0t: expected hit=%0b error=%0b, actual hit=%0b error=%0b",
                     $time, e.hit, e.error, out_hit, out_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= verdicts.size();
    end
  end
endmodule

@@ verif/polyline_hit_test_tb.sv @@
// ----------------------------------------------------------------------------
// polyline_hit_test_tb: stimulus and verdict for the polyline hit test
// Drives clear/append/query/unused-op transactions with random gaps and output
// stalls across several half widths; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module polyline_hit_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phit_pkg::*;

  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int FILL_POINTS = 200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op = OP_CLEAR;
  logic signed [19:0] in_x = '0;
  logic signed [19:0] in_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic               out_error;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  coord_t             cx, cy;

  always #5 clk = ~clk;

  polyline_hit_test u_dut (.*);
  polyline_hit_test_chk u_chk (.*);

  // Abort if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: at random, hold out_stall high before taking each result.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(4);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Send one transaction after a random gap; return at its acceptance.
  task automatic send(input op_t op, input coord_t x, input coord_t y);
    int gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_x <= x;
    in_y <= y;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Drain all results, wait out trailing latency, then write half width.
  task automatic set_half_width(input logic [15:0] hw);
    int waited;
    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= hw;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // Random stroke: a walk of small steps from a random start.
  task automatic random_stroke(input int len, input int step);
    cx = coord_t'(int'($urandom_range(4095)) - 2048);
    cy = coord_t'(int'($urandom_range(4095)) - 2048);
    for (int i = 0; i < len; i++) begin
      cx = coord_t'(cx + int'($urandom_range(2 * step)) - step);
      cy = coord_t'(cy + int'($urandom_range(2 * step)) - step);
      send(OP_APPEND, cx, cy);
    end
  endtask

  initial begin
    int op_pick;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: query on empty store, extremes, odd-offset point, unused op.
    send(OP_QUERY, '0, '0);
    send(OP_APPEND, 20'sh80000, 20'sh7FFFF);
    send(OP_APPEND, 20'sh7FFFF, 20'sh80000);
    send(OP_QUERY, 20'sh80000, 20'sh7FFFF);
    send(OP_QUERY, 20'sh7FFFF, 20'sh80000);
    send(OP_QUERY, '0, '0);
    send(OP_NONE, 20'sh7FFFF, 20'sh7FFFF);
    send(OP_CLEAR, '0, '0);
    send(OP_QUERY, '0, '0);
    send(OP_APPEND, '0, '0);
    send(OP_QUERY, 20'sd15, '0);   // just inside the width
    send(OP_QUERY, 20'sd16, '0);   // on the width: miss
    send(OP_QUERY, 20'sd12, 20'sd12);
    send(OP_QUERY, 20'sd16, 20'sd16);

    set_half_width(16'd0);       // zero width never hits
    send(OP_QUERY, '0, '0);
    set_half_width(16'hFFFF);
    send(OP_QUERY, 20'sh7FFFF, 20'sh7FFFF);
    send(OP_QUERY, 20'sh80000, 20'sh80000);

    // Fill the store across many leaves, then query inside and at the end.
    set_half_width(16'd64);
    send(OP_CLEAR, '0, '0);
    for (int i = 0; i < FILL_POINTS; i++)
      send(OP_APPEND, coord_t'(i * 37), coord_t'(-i * 11));
    send(OP_QUERY, coord_t'(100 * 37), coord_t'(-100 * 11));
    send(OP_QUERY, coord_t'((FILL_POINTS - 1) * 37 + 40),
         coord_t'(-(FILL_POINTS - 1) * 11));
    send(OP_CLEAR, '0, '0);

    // Random phases over several widths; mostly short strokes plus queries.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_half_width(16'd16);
        1: set_half_width(16'd1);
        2: set_half_width(16'd200);
        3: set_half_width(16'hFFFF);
        4: set_half_width(16'($urandom));
        default: set_half_width(16'd40);
      endcase
      for (int s = 0; s < 4; s++) begin
        send(OP_CLEAR, rand_coord(), rand_coord());
        random_stroke($urandom_range(1, 20), 64);
        for (int q = 0; q < 10; q++) begin
          op_pick = $urandom_range(9);
          if (op_pick < 7)
            send(OP_QUERY, coord_t'(cx + int'($urandom_range(512)) - 256),
                 coord_t'(cy + int'($urandom_range(512)) - 256));
          else if (op_pick == 7) send(OP_QUERY, rand_coord(), rand_coord());
          else if (op_pick == 8) send(OP_APPEND, rand_coord(), rand_coord());
          else send(OP_NONE, rand_coord(), rand_coord());
        end
      end
    end

    // Wait for the last results and trailing latency.
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/phit_pkg.sv
design/phit_front.sv
design/phit_queue.sv
design/phit_back.sv
design/polyline_hit_test.sv
verif/polyline_hit_test_chk.sv
verif/polyline_hit_test_tb.sv
